FILE: hdl/icn_pkg.sv
// Package for the integer to Chinese numeral converter.
// Holds symbol codes, widths and the front-to-back descriptor type. No dependencies.
package icn_pkg;

  localparam int ValueW = 64;
  localparam int SymW   = 4;
  localparam int NDig   = 20;
  localparam int BcdW   = NDig * 4;
  localparam int QDepth = 2;

  localparam logic [SymW-1:0] SYM_ZERO     = 4'd0;
  localparam logic [SymW-1:0] SYM_ONE      = 4'd1;
  localparam logic [SymW-1:0] SYM_TEN      = 4'd10;
  localparam logic [SymW-1:0] SYM_HUNDRED  = 4'd11;
  localparam logic [SymW-1:0] SYM_THOUSAND = 4'd12;
  localparam logic [SymW-1:0] SYM_WAN      = 4'd13;

  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_DIGITS,
    MODE_GROUPS
  } mode_t;

  typedef struct packed {
    mode_t           mode;
    logic [BcdW-1:0] bcd;
  } desc_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_CONV,
    FS_PUSH
  } fstate_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_RUN
  } bstate_t;

endpackage

FILE: hdl/icn_front.sv
// Front end: accepts a value, converts it to BCD by shift and add-three, classifies it.
// Depends on icn_pkg.
module icn_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [icn_pkg::ValueW-1:0]  in_value,
  output logic                        d_valid,
  input  logic                        d_ready,
  output icn_pkg::desc_t              d_data
);
  import icn_pkg::*;

  fstate_t               st_r, st_nxt;
  logic [ValueW-1:0]     bin_r, bin_nxt;
  logic [BcdW-1:0]       bcd_r, bcd_nxt, adj;
  logic [6:0]            cnt_r, cnt_nxt;
  logic                  big;

  always_comb begin
    for (int i = 0; i < NDig; i++) begin
      adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3 : bcd_r[i*4 +: 4];
    end
  end

  assign big = (bcd_r[BcdW-1:64] != '0);

  always_comb begin
    st_nxt  = st_r;
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    in_full = 1'b1;
    d_valid = 1'b0;
    d_data.bcd  = bcd_r;
    d_data.mode = (bcd_r == '0) ? MODE_ZERO : (big ? MODE_DIGITS : MODE_GROUPS);
    unique case (st_r)
      FS_IDLE: begin
        in_full = 1'b0;
        if (in_push) begin
          bin_nxt = in_value;
          bcd_nxt = '0;
          cnt_nxt = '0;
          st_nxt  = FS_CONV;
        end
      end
      FS_CONV: begin
        bcd_nxt = {adj[BcdW-2:0], bin_r[ValueW-1]};
        bin_nxt = {bin_r[ValueW-2:0], 1'b0};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(ValueW - 1)) st_nxt = FS_PUSH;
      end
      FS_PUSH: begin
        d_valid = 1'b1;
        if (d_ready) st_nxt = FS_IDLE;
      end
      default: st_nxt = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= FS_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
  end
endmodule

FILE: hdl/icn_queue.sv
// Short descriptor queue between front and back ends.
// Depends on icn_pkg.
module icn_queue #(
  parameter int Depth = icn_pkg::QDepth
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           w_valid,
  output logic           w_ready,
  input  icn_pkg::desc_t w_data,
  output logic           r_valid,
  input  logic           r_ready,
  output icn_pkg::desc_t r_data
);
  import icn_pkg::*;
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  desc_t           mem_r [Depth];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r;
  logic            wr, rd;

  assign w_ready = (cnt_r != (AW+1)'(Depth));
  assign r_valid = (cnt_r != '0);
  assign r_data  = mem_r[rp_r];
  assign wr = w_valid && w_ready;
  assign rd = r_valid && r_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(Depth - 1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == AW'(Depth - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
    if (wr) mem_r[wp_r] <= w_data;
  end
endmodule

FILE: hdl/icn_back.sv
// Back end: walks the BCD digits of one value and emits its reading into an output register.
// Depends on icn_pkg.
module icn_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       d_valid,
  output logic                       d_ready,
  input  icn_pkg::desc_t             d_data,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [icn_pkg::SymW-1:0]   out_symbol,
  output logic                       out_last
);
  import icn_pkg::*;

  bstate_t          st_r, st_nxt;
  desc_t            dsc_r, dsc_nxt;
  logic [4:0]       pos_r, pos_nxt;
  logic [1:0]       sub_r, sub_nxt;
  logic             pend_r, pend_nxt;
  logic             emitted_r, emitted_nxt;
  logic [SymW-1:0]  prev_r, prev_nxt;
  logic             ov_r, ov_nxt;
  logic [SymW-1:0]  osym_r, osym_nxt;
  logic             olast_r, olast_nxt;

  logic [3:0]       dg;
  logic [1:0]       gi, dp;
  logic [15:0]      grp, low, upg;
  logic             grp_nz, low_nz, more_nz, prefix;
  logic             want, islast;
  logic [SymW-1:0]  wsym;
  logic             adv, fin, slot_free;
  logic             hi_nz;

  assign slot_free = !ov_r || out_pop;
  assign out_empty = !ov_r;
  assign out_symbol = osym_r;
  assign out_last = olast_r;

  always_comb begin
    dg  = dsc_r.bcd[pos_r*4 +: 4];
    gi  = pos_r[3:2];
    dp  = pos_r[1:0];
    grp = dsc_r.bcd[gi*16 +: 16];
    upg = dsc_r.bcd[gi*16 + 16 +: 16];
    low = grp & ((16'h1 << (dp*4)) - 16'h1);
    grp_nz = (grp != '0);
    low_nz = (low != '0);
    hi_nz = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (k > dp && grp[k*4 +: 4] != '0) hi_nz = 1'b1;
    end
    more_nz = 1'b0;
    for (int k = 0; k < 16; k++) begin
      if (k < pos_r && dsc_r.bcd[k*4 +: 4] != '0) more_nz = 1'b1;
    end
    prefix = emitted_r;
  end

  // Sub-steps per digit position in group mode: 0 zero insert, 1 digit, 2 unit, 3 group unit.
  always_comb begin
    want   = 1'b0;
    wsym   = dg;
    fin    = 1'b0;
    islast = 1'b0;
    unique case (dsc_r.mode)
      MODE_ZERO: begin
        want   = 1'b1;
        wsym   = SYM_ZERO;
        fin    = 1'b1;
        islast = 1'b1;
      end
      MODE_DIGITS: begin
        want = emitted_r || (dg != '0) || (dsc_r.bcd >> (pos_r*4)) != '0;
        wsym = dg;
        fin  = (pos_r == '0);
        islast = (pos_r == '0);
        if (!emitted_r && dsc_r.bcd[pos_r*4 +: 4] == '0 &&
            (dsc_r.bcd >> (pos_r*4)) == '0) want = 1'b0;
      end
      default: begin
        unique case (sub_r)
          2'd0: begin
            want = grp_nz && (dg != '0) && emitted_r && (pend_r || !hi_nz)
                   && (prev_r != SYM_ZERO)
                   && (dp == 2'd3 ? 1'b0 : 1'b1);
            if (dp == 2'd3) want = (dg != '0) && emitted_r && (upg == '0);
            wsym = SYM_ZERO;
          end
          2'd1: begin
            want = (dg != '0) && !(dp == 2'd1 && dg == SYM_ONE && !prefix);
            wsym = dg;
            islast = (pos_r == '0);
          end
          2'd2: begin
            want = (dg != '0) && (dp != 2'd0);
            wsym = (dp == 2'd3) ? SYM_THOUSAND : ((dp == 2'd2) ? SYM_HUNDRED : SYM_TEN);
            islast = (gi == 2'd0) && !low_nz;
          end
          default: begin
            want = (dp == 2'd0) && grp_nz && (gi != 2'd0);
            wsym = SYM_WAN + SymW'(gi) - 4'd1;
            islast = !more_nz;
          end
        endcase
        fin = (pos_r == '0) && (sub_r == 2'd3 || !more_nz) && !low_nz;
      end
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    dsc_nxt = dsc_r;
    pos_nxt = pos_r;
    sub_nxt = sub_r;
    pend_nxt = pend_r;
    emitted_nxt = emitted_r;
    prev_nxt = prev_r;
    ov_nxt = ov_r && !out_pop;
    osym_nxt = osym_r;
    olast_nxt = olast_r;
    d_ready = 1'b0;
    adv = 1'b0;
    unique case (st_r)
      BS_IDLE: begin
        d_ready = 1'b1;
        if (d_valid) begin
          dsc_nxt = d_data;
          pos_nxt = (d_data.mode == MODE_DIGITS) ? 5'(NDig - 1) : 5'd15;
          sub_nxt = '0;
          pend_nxt = 1'b0;
          emitted_nxt = 1'b0;
          prev_nxt = SYM_TEN;
          st_nxt = BS_RUN;
        end
      end
      BS_RUN: begin
        if (!want) begin
          adv = 1'b1;
        end else if (slot_free) begin
          adv = 1'b1;
          ov_nxt = 1'b1;
          osym_nxt = wsym;
          emitted_nxt = 1'b1;
          prev_nxt = wsym;
        end
        if (adv) begin
          if (dsc_r.mode == MODE_GROUPS) begin
            if (sub_r == 2'd1 && dg == '0 && emitted_r && grp_nz) pend_nxt = 1'b1;
            if (sub_r == 2'd3 && dp == 2'd0 && !grp_nz && emitted_r) pend_nxt = 1'b1;
            if (sub_r == 2'd1 && dg != '0) pend_nxt = 1'b0;
            if (want && wsym == SYM_ZERO && sub_r == 2'd0) pend_nxt = 1'b0;
          end
          if (want) olast_nxt = islast;
          if (fin && (dsc_r.mode != MODE_GROUPS || sub_r == 2'd3)) begin
            st_nxt = BS_IDLE;
          end else if (dsc_r.mode == MODE_GROUPS && sub_r != 2'd3) begin
            sub_nxt = sub_r + 2'd1;
          end else begin
            sub_nxt = '0;
            pos_nxt = pos_r - 5'd1;
          end
        end
      end
      default: st_nxt = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BS_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
    dsc_r <= dsc_nxt;
    pos_r <= pos_nxt;
    sub_r <= sub_nxt;
    pend_r <= pend_nxt;
    emitted_r <= emitted_nxt;
    prev_r <= prev_nxt;
    osym_r <= osym_nxt;
    olast_r <= olast_nxt;
  end
endmodule

FILE: hdl/integer_to_chinese_numeral.sv
// Integer to Chinese numeral converter, top level.
// Instantiates icn_front, icn_queue and icn_back; depends on icn_pkg.
//
// Usage: values enter through a queue-like port (in_push, in_full, in_value).
// An item is taken when in_push is high and in_full is low. Each value becomes
// one to 31 symbols on out_symbol, the final one flagged by out_last. Results
// are read like a queue: out_empty low shows a symbol, out_pop takes it.
// The front end converts binary to BCD with one shift-add-three step per
// cycle and takes no new value until it has handed its descriptor on. The
// back end takes a descriptor, then walks four steps for each of the 16
// positions of a value below 10^16, one step for each of the 20 digits of a
// larger value, or a single step for zero; each step emits at most one
// symbol. A two-entry queue lets the front convert the next value while
// the back is still emitting. When the receiver stalls, the output register
// holds its symbol, the back end waits, the queue fills and in_full rises.
// Synchronous reset empties all stages.
module integer_to_chinese_numeral #(
  parameter int QueueDepth = icn_pkg::QDepth
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [icn_pkg::ValueW-1:0] in_value,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [icn_pkg::SymW-1:0]   out_symbol,
  output logic                       out_last
);
  import icn_pkg::*;

  desc_t f_data, b_data;
  logic  f_valid, f_ready, b_valid, b_ready;

  icn_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_value,
    .d_valid(f_valid), .d_ready(f_ready), .d_data(f_data)
  );

  icn_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst_n,
    .w_valid(f_valid), .w_ready(f_ready), .w_data(f_data),
    .r_valid(b_valid), .r_ready(b_ready), .r_data(b_data)
  );

  icn_back u_back (
    .clk, .rst_n,
    .d_valid(b_valid), .d_ready(b_ready), .d_data(b_data),
    .out_empty, .out_pop, .out_symbol, .out_last
  );
endmodule

FILE: hdl/icn_checker.sv
// Port-level checker for the converter, bound to the top level.
// Depends on the top level's ports only.
module icn_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_push,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [3:0] out_symbol,
  input logic       out_last
);
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("Result seen right after reset.");
  a_reset_free: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("Input blocked right after reset.");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_symbol) && $stable(out_last)))
    else $error("Waiting item changed.");
  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> in_full)
    else $error("Front end took two items in a row.");
endmodule

bind integer_to_chinese_numeral icn_checker u_checker (
  .clk, .rst_n, .in_push, .in_full, .out_empty, .out_pop, .out_symbol, .out_last
);
